@@ rtl/core/dne_pkg.sv @@
// Package for the decimal number encoder: widths, character codes, types.
// No dependencies.
`default_nettype none
package dne_pkg;
  localparam int ValueWidth = 64;
  localparam int MaxDigits  = 20;
  localparam int DigitCntW  = 5;
  localparam int CharWidth  = 8;
  localparam logic [CharWidth-1:0] CharZero = 8'd48;
  localparam logic [CharWidth-1:0] CharTerm = 8'd124;

  typedef logic [MaxDigits-1:0][3:0] bcd_t;

  typedef struct packed {
    bcd_t                 digits;
    logic [DigitCntW-1:0] ndig;
  } dec_word_t;
endpackage
`default_nettype wire

@@ rtl/core/dne_convert.sv @@
// Binary to BCD conversion pipeline (double dabble, eight bits per stage).
// Depends on dne_pkg.
`default_nettype none
module dne_convert
  import dne_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [ValueWidth-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output dec_word_t                  out_word
);
  localparam int NStage = 8;
  localparam int BitsPerStage = ValueWidth / NStage;

  // stage registers
  logic [NStage-1:0]                 vld;
  logic [NStage-1:0][ValueWidth-1:0] bin;
  bcd_t                              bcd [NStage];
  logic [NStage-1:0]                 adv;
  logic                              cnt_vld;
  dec_word_t                         cnt_word;
  logic                              cnt_adv;

  function automatic bcd_t dabble_step(input bcd_t b, input logic bit_in);
    bcd_t r;
    logic [MaxDigits*4-1:0] flat;
    r = b;
    for (int d = 0; d < MaxDigits; d++) begin
      if (r[d] >= 4'd5) r[d] = r[d] + 4'd3;
    end
    flat = {r[MaxDigits-1:0]};
    flat = {flat[MaxDigits*4-2:0], bit_in};
    return bcd_t'(flat);
  endfunction

  // stall handling: a stage moves when the next is empty or moving
  assign cnt_adv = !cnt_vld || out_ready;
  always_comb begin
    adv[NStage-1] = !vld[NStage-1] || cnt_adv;
    for (int s = NStage-2; s >= 0; s--) adv[s] = !vld[s] || adv[s+1];
  end
  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    bcd_t t;
    logic [ValueWidth-1:0] sb;
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int s = 1; s < NStage; s++) begin
        if (adv[s]) vld[s] <= vld[s-1];
      end
    end
    for (int s = 0; s < NStage; s++) begin
      if (adv[s]) begin
        t  = (s == 0) ? bcd_t'('0) : bcd[s-1];
        sb = (s == 0) ? in_value : bin[s-1];
        for (int k = 0; k < BitsPerStage; k++) begin
          t  = dabble_step(t, sb[ValueWidth-1]);
          sb = {sb[ValueWidth-2:0], 1'b0};
        end
        bcd[s] <= t;
        bin[s] <= sb;
      end
    end
  end

  // digit count: position of the top nonzero digit, at least one
  always_ff @(posedge clk) begin
    logic [DigitCntW-1:0] n;
    if (rst) begin
      cnt_vld <= 1'b0;
    end else if (cnt_adv) begin
      cnt_vld <= vld[NStage-1];
    end
    if (cnt_adv) begin
      n = DigitCntW'(1);
      for (int d = 1; d < MaxDigits; d++) begin
        if (bcd[NStage-1][d] != 4'd0) n = DigitCntW'(d + 1);
      end
      cnt_word.digits <= bcd[NStage-1];
      cnt_word.ndig   <= n;
    end
  end

  assign out_valid = cnt_vld;
  assign out_word  = cnt_word;

  a_ndig_range: assert property (@(posedge clk) disable iff (rst)
    cnt_vld |-> (cnt_word.ndig >= DigitCntW'(1) && cnt_word.ndig <= DigitCntW'(MaxDigits)))
    else $error("digit count out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    cnt_vld && !out_ready |=> cnt_vld && $stable(cnt_word))
    else $error("converted word changed under stall");
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    vld[NStage-1] && !cnt_adv |=> vld[NStage-1])
    else $error("stage item lost");
endmodule
`default_nettype wire

@@ rtl/core/decimal_number_encoder_core.sv @@
// Top level of the decimal number encoder: BCD pipeline plus character emitter.
// Depends on dne_pkg and dne_convert.
`default_nettype none
// Each 64-bit request is turned into its decimal ASCII digits, most
// significant first, no leading zeros, then a '|' character with last_char
// set. A value of n digits leaves as n+1 characters, one per cycle at
// most, fewer while out_ready is low; the single character emitter sets
// that rate. Conversion runs in a nine-stage pipeline (eight double-dabble
// stages, eight bits each, plus a digit count stage) followed by the
// emitter register, which presents the first character once the word
// has passed the digit count stage; later requests convert while earlier
// ones are still being emitted.
module decimal_number_encoder_core
  import dne_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [ValueWidth-1:0] number_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [CharWidth-1:0]       out_char,
  output logic                       last_char
);
  logic      cv_valid;
  logic      cv_ready;
  dec_word_t cv_word;

  // emitter state
  logic                 busy;
  bcd_t                 digits;
  logic [DigitCntW-1:0] remain; // digits still to send; zero means terminator
  logic                 fire;

  dne_convert u_convert (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_value  (number_value),
    .out_valid (cv_valid),
    .out_ready (cv_ready),
    .out_word  (cv_word)
  );

  assign fire      = busy && out_ready;
  // load the next word when idle or when the terminator just left
  assign cv_ready  = !busy || (fire && remain == '0);
  assign out_valid = busy;
  assign last_char = (remain == '0);
  always_comb begin
    if (remain == '0) begin
      out_char = CharTerm;
    end else begin
      out_char = CharZero + CharWidth'(digits[remain - DigitCntW'(1)]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cv_ready) begin
      busy <= cv_valid;
    end
    if (cv_ready) begin
      digits <= cv_word.digits;
      remain <= cv_word.ndig;
    end else if (fire) begin
      remain <= remain - DigitCntW'(1);
    end
  end

  a_remain_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> remain <= DigitCntW'(MaxDigits))
    else $error("remaining digit count out of range");
  a_step: assert property (@(posedge clk) disable iff (rst)
    fire && remain != '0 |=> busy && remain == $past(remain) - DigitCntW'(1))
    else $error("emitter skipped a digit");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    busy && !out_ready |=> busy && $stable(remain))
    else $error("emitter moved under stall");
endmodule
`default_nettype wire
